>>> design/assert_macros.svh
// Assertion helpers used by the scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define NNIS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nnis same-cycle check failed");

// Next-cycle implication, checked on clk, off while rst_n is low.
`define NNIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nnis next-cycle check failed");

`endif

>>> design/nnis_pkg.sv
`timescale 1ns / 1ps

package nnis_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_COLORS = 4;

    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CLR_W  = $clog2(MAX_COLORS);
    localparam int ADDR_W = ROW_W + COL_W + CLR_W;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_COLORS;

    localparam int DIM_W      = 9;
    localparam int CCNT_W     = 3;
    localparam int COORD_W    = 16;
    localparam int CIDX_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int SCALE_W    = 16;
    localparam int SCALE_FRAC = 8;
    localparam int HDR_W      = 16;
    localparam int SIZE_W     = 34;
    localparam int ROW_ALIGN  = 4;

    localparam int MUL_A_W   = 18;
    localparam int MUL_B_W   = 16;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_STEPS = MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_STEPS);

    localparam int DIV_N_W   = COORD_W + SCALE_FRAC;
    localparam int DIV_D_W   = SCALE_W;
    localparam int DIV_STEPS = DIV_N_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 3'd4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] pix_row;
        logic [COORD_W-1:0] pix_col;
        logic [CIDX_W-1:0]  color_index;
        logic [BYTE_W-1:0]  write_value;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  pixel_value;
        logic               out_of_range;
        logic [COORD_W-1:0] scaled_width;
        logic [COORD_W-1:0] scaled_height;
        logic [SIZE_W-1:0]  new_data_size;
    } out_item_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } store_req_t;

endpackage

>>> design/nnis_mul.sv
`timescale 1ns / 1ps

module nnis_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nnis_pkg::MUL_A_W-1:0]  a,
    input  logic [nnis_pkg::MUL_B_W-1:0]  b,
    output logic [nnis_pkg::MUL_P_W-1:0]  product,
    output logic                          busy
);
    import nnis_pkg::*;

    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_P_W-1:0]   prod_reg;
    logic [MUL_P_W-1:0]   prod_next;
    logic [MUL_A_W:0]     sum;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    // shift-add, one multiplier bit per cycle, LSB first
    always_comb
    begin
        sum       = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]}
                  + (prod_reg[0] ? {1'b0, a_reg} : '0);
        prod_next = {sum, prod_reg[MUL_B_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            a_reg    <= '0;
            prod_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            a_reg    <= a;
            prod_reg <= {{MUL_A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign product = prod_reg;
    assign busy    = busy_reg;

endmodule

>>> design/nnis_div.sv
`timescale 1ns / 1ps

module nnis_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nnis_pkg::DIV_N_W-1:0]  dividend,
    input  logic [nnis_pkg::DIV_D_W-1:0]  divisor,
    output logic [nnis_pkg::DIV_N_W-1:0]  quotient,
    output logic                          busy
);
    import nnis_pkg::*;

    logic [DIV_N_W-1:0]   dvd_reg;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DIV_N_W-1]};
        ge      = (shifted >= {1'b0, dsr_reg});
        diff    = shifted - {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_N_W-2:0], 1'b0};
            rem_reg <= ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

>>> design/nnis_store.sv
`timescale 1ns / 1ps

module nnis_store (
    input  logic                         clk,
    input  nnis_pkg::store_req_t         req,
    output logic [nnis_pkg::BYTE_W-1:0]  rdata
);
    import nnis_pkg::*;

    logic [BYTE_W-1:0] mem [STORE_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/nearest_neighbor_image_scaler.sv
// Nearest-neighbor image scaler over a 256 x 256 x 4 byte source frame store.
// Request channel (req_valid / req_stall / req_item): cmd 0 writes one source
// byte, cmd 1 fetches one output byte of the scaled image. A beat is taken
// when req_valid is high and req_stall is low.
// Response channel (rsp_valid / rsp_stall / rsp_item): one beat per request,
// carrying the byte, the out-of-range flag, the scaled size and BMP data size.
// Configuration: cfg_we with cfg_index / cfg_data, write only while idle.
// The block takes one request at a time, so a new request can be taken in the
// cycle after the previous response is loaded. The pace is set by the serial
// multiplier, which runs the size product and then the data-size product;
// the two serial dividers start with the first and finish during the second.
// A finished response sits in the output register while the next request is
// taken; a stalled response holds, and only a second finished response waits
// for it. Reset clears the configuration to 256 x 256, 3 colors, scale 1.0,
// header 54, and empties the response register. The store is not cleared;
// fetching a byte never written returns an undefined value.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nearest_neighbor_image_scaler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  nnis_pkg::in_item_t                req_item,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output nnis_pkg::out_item_t               rsp_item,
    input  logic                              cfg_we,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import nnis_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_SIZE, ST_PREP, ST_DATA, ST_FINISH} state_t;

    state_t              state_reg;
    logic [DIM_W-1:0]    src_width_reg;
    logic [DIM_W-1:0]    src_height_reg;
    logic [CCNT_W-1:0]   color_count_reg;
    logic [SCALE_W-1:0]  scale_q_reg;
    logic [HDR_W-1:0]    header_bytes_reg;

    in_item_t            item_reg;
    logic [COORD_W-1:0]  sw_reg;
    logic [COORD_W-1:0]  sh_reg;
    logic                oor_reg;
    logic [SIZE_W-1:0]   data_size_reg;
    logic                rsp_valid_reg;
    out_item_t           rsp_reg;

    logic [DIM_W-1:0]    w_clamp;
    logic [DIM_W-1:0]    h_clamp;
    logic [CCNT_W-1:0]   c_clamp;
    logic                accept;
    logic                data_go;
    logic                load_ok;
    logic [MUL_A_W-1:0]  rb_raw;
    logic [MUL_A_W-1:0]  row_bytes;

    logic                mul0_start;
    logic [MUL_A_W-1:0]  mul0_a;
    logic [MUL_B_W-1:0]  mul0_b;
    logic [MUL_P_W-1:0]  mul0_product;
    logic                mul0_busy;
    logic [MUL_P_W-1:0]  mul1_product;
    logic                mul1_busy;
    logic [DIV_N_W-1:0]  quo_row;
    logic [DIV_N_W-1:0]  quo_col;
    logic                divr_busy;
    logic                divc_busy;

    logic [DIM_W-1:0]    row_sel;
    logic [DIM_W-1:0]    col_sel;
    logic                fetch_ok;
    logic                write_ok;
    store_req_t          store_req;
    logic [BYTE_W-1:0]   store_rdata;

    function automatic logic [COORD_W-1:0] sat_dim(input logic [MUL_P_W-1:0] p);
        logic [COORD_W-1:0] r;
        if (|p[MUL_P_W-1:SCALE_FRAC+COORD_W])
        begin
            r = '1;
        end
        else
        begin
            r = p[SCALE_FRAC+COORD_W-1:SCALE_FRAC];
        end
        return r;
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg    <= DIM_W'(256);
            src_height_reg   <= DIM_W'(256);
            color_count_reg  <= CCNT_W'(3);
            scale_q_reg      <= SCALE_W'(256);
            header_bytes_reg <= HDR_W'(54);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:    src_width_reg    <= cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT:   src_height_reg   <= cfg_data[DIM_W-1:0];
                CFG_COLOR_COUNT:  color_count_reg  <= cfg_data[CCNT_W-1:0];
                CFG_SCALE_Q:      scale_q_reg      <= cfg_data[SCALE_W-1:0];
                CFG_HEADER_BYTES: header_bytes_reg <= cfg_data[HDR_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        w_clamp = (src_width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : src_width_reg;
        h_clamp = (src_height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                        : src_height_reg;
        c_clamp = (color_count_reg > CCNT_W'(MAX_COLORS)) ? CCNT_W'(MAX_COLORS)
                                                          : color_count_reg;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign load_ok   = !rsp_valid_reg || !rsp_stall;
    assign data_go   = (state_reg == ST_DATA) && !mul0_busy && !divr_busy && !divc_busy;

    // padded row bytes: sw * c rounded up to the row alignment
    always_comb
    begin
        rb_raw    = (c_clamp[0] ? MUL_A_W'(sw_reg) : '0)
                  + (c_clamp[1] ? MUL_A_W'({sw_reg, 1'b0}) : '0)
                  + (c_clamp[2] ? MUL_A_W'({sw_reg, 2'b00}) : '0);
        row_bytes = (rb_raw + MUL_A_W'(ROW_ALIGN - 1)) & ~MUL_A_W'(ROW_ALIGN - 1);
    end

    always_comb
    begin
        mul0_start = accept || (state_reg == ST_PREP);
        if (state_reg == ST_IDLE)
        begin
            mul0_a = MUL_A_W'(scale_q_reg);
            mul0_b = MUL_B_W'(w_clamp);
        end
        else
        begin
            mul0_a = row_bytes;
            mul0_b = sh_reg;
        end
    end

    nnis_mul u_mul0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul0_start),
        .a       (mul0_a),
        .b       (mul0_b),
        .product (mul0_product),
        .busy    (mul0_busy)
    );

    nnis_mul u_mul1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .a       (MUL_A_W'(scale_q_reg)),
        .b       (MUL_B_W'(h_clamp)),
        .product (mul1_product),
        .busy    (mul1_busy)
    );

    nnis_div u_div_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend ({req_item.pix_row, {SCALE_FRAC{1'b0}}}),
        .divisor  (scale_q_reg),
        .quotient (quo_row),
        .busy     (divr_busy)
    );

    nnis_div u_div_col (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend ({req_item.pix_col, {SCALE_FRAC{1'b0}}}),
        .divisor  (scale_q_reg),
        .quotient (quo_col),
        .busy     (divc_busy)
    );

    // source coordinates, clamped to the last row / column on fetch
    always_comb
    begin
        if (item_reg.cmd == CMD_FETCH)
        begin
            row_sel = (quo_row >= DIV_N_W'(h_clamp)) ? h_clamp - DIM_W'(1)
                                                     : quo_row[DIM_W-1:0];
            col_sel = (quo_col >= DIV_N_W'(w_clamp)) ? w_clamp - DIM_W'(1)
                                                     : quo_col[DIM_W-1:0];
        end
        else
        begin
            row_sel = item_reg.pix_row[DIM_W-1:0];
            col_sel = item_reg.pix_col[DIM_W-1:0];
        end
        store_req.we    = data_go && (item_reg.cmd == CMD_WRITE) && !oor_reg;
        store_req.re    = data_go && (item_reg.cmd == CMD_FETCH) && !oor_reg;
        store_req.addr  = {row_sel[ROW_W-1:0], col_sel[COL_W-1:0],
                           item_reg.color_index[CLR_W-1:0]};
        store_req.wdata = item_reg.write_value;
    end

    nnis_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (store_rdata)
    );

    always_comb
    begin
        fetch_ok = (item_reg.pix_row < sh_reg) && (item_reg.pix_col < sw_reg)
                && ({1'b0, item_reg.color_index} < c_clamp)
                && (scale_q_reg != '0);
        write_ok = (item_reg.pix_row < COORD_W'(h_clamp))
                && (item_reg.pix_col < COORD_W'(w_clamp))
                && ({1'b0, item_reg.color_index} < c_clamp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            item_reg      <= '0;
            sw_reg        <= '0;
            sh_reg        <= '0;
            oor_reg       <= 1'b0;
            data_size_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if ((state_reg == ST_FINISH) && load_ok)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg  <= req_item;
                        state_reg <= ST_SIZE;
                    end
                end
                ST_SIZE:
                begin
                    if (!mul0_busy && !mul1_busy)
                    begin
                        sw_reg    <= sat_dim(mul0_product);
                        sh_reg    <= sat_dim(mul1_product);
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    oor_reg   <= (item_reg.cmd == CMD_FETCH) ? !fetch_ok : !write_ok;
                    state_reg <= ST_DATA;
                end
                ST_DATA:
                begin
                    if (data_go)
                    begin
                        data_size_reg <= SIZE_W'(header_bytes_reg) + mul0_product;
                        state_reg     <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (load_ok)
                    begin
                        rsp_reg.pixel_value   <= ((item_reg.cmd == CMD_FETCH) && !oor_reg)
                                                 ? store_rdata : '0;
                        rsp_reg.out_of_range  <= oor_reg;
                        rsp_reg.scaled_width  <= sw_reg;
                        rsp_reg.scaled_height <= sh_reg;
                        rsp_reg.new_data_size <= data_size_reg;
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    `NNIS_ASSERT_NEXT(a_accept_busy, accept, req_stall && (state_reg == ST_SIZE))
    `NNIS_ASSERT_SAME(a_oor_zero, rsp_valid && rsp_item.out_of_range, rsp_item.pixel_value == '0)
    `NNIS_ASSERT_SAME(a_store_quiet, state_reg != ST_DATA, !store_req.we && !store_req.re)
    `NNIS_ASSERT_SAME(a_units_idle, state_reg == ST_FINISH, !mul0_busy && !divr_busy && !divc_busy)

endmodule

>>> sim/nnis_checker.sv
`timescale 1ns / 1ps

module nnis_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  nnis_pkg::in_item_t              req_item,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  nnis_pkg::out_item_t             rsp_item,
    input  logic                            cfg_we,
    input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              pending,
    output int                              checked,
    output int                              fetch_hits
);
    import nnis_pkg::*;

    logic [BYTE_W-1:0]  src_bytes [STORE_DEPTH];
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [CCNT_W-1:0]  colors_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [HDR_W-1:0]   header_reg;
    out_item_t          due_beats [$];
    out_item_t          oldest;

    initial
    begin
        mismatches = 0;
        checked    = 0;
        fetch_hits = 0;
        pending    = 0;
    end

    // Applies a request beat to the frame copy and returns the response it owes.
    function automatic out_item_t resample_beat(in_item_t beat);
        out_item_t       r;
        longint unsigned w, h, c, sw, sh, row_bytes, sr, sc;
        w  = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h  = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        c  = (colors_reg > MAX_COLORS) ? MAX_COLORS : colors_reg;
        sw = (w * scale_reg) >> SCALE_FRAC;
        sh = (h * scale_reg) >> SCALE_FRAC;
        if (sw > 65535)
            sw = 65535;
        if (sh > 65535)
            sh = 65535;
        row_bytes = (sw * c + ROW_ALIGN - 1) / ROW_ALIGN * ROW_ALIGN;
        r = '0;
        r.scaled_width  = sw[COORD_W-1:0];
        r.scaled_height = sh[COORD_W-1:0];
        r.new_data_size = SIZE_W'(header_reg + sh * row_bytes);
        if (beat.cmd == CMD_WRITE)
        begin
            if (beat.pix_row < h && beat.pix_col < w && beat.color_index < c)
                src_bytes[{beat.pix_row[7:0], beat.pix_col[7:0], beat.color_index}] =
                    beat.write_value;
            else
                r.out_of_range = 1'b1;
        end
        else if (beat.pix_row < sh && beat.pix_col < sw && beat.color_index < c
                 && scale_reg != 0)
        begin
            sr = {beat.pix_row, 8'h00} / scale_reg;
            sc = {beat.pix_col, 8'h00} / scale_reg;
            if (sr >= h)
                sr = h - 1;
            if (sc >= w)
                sc = w - 1;
            r.pixel_value = src_bytes[{sr[7:0], sc[7:0], beat.color_index}];
            fetch_hits++;
        end
        else
        begin
            r.out_of_range = 1'b1;
        end
        return r;
    endfunction

    task automatic note_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            colors_reg <= 3'd3;
            scale_reg  <= 16'd256;
            header_reg <= 16'd54;
            due_beats.delete();
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SRC_WIDTH:    width_reg  <= cfg_data[DIM_W-1:0];
                    CFG_SRC_HEIGHT:   height_reg <= cfg_data[DIM_W-1:0];
                    CFG_COLOR_COUNT:  colors_reg <= cfg_data[CCNT_W-1:0];
                    CFG_SCALE_Q:      scale_reg  <= cfg_data;
                    CFG_HEADER_BYTES: header_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (req_valid && !req_stall)
                due_beats.push_back(resample_beat(req_item));
            if (rsp_valid && !rsp_stall)
            begin
                if (due_beats.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: response beat with none outstanding, expected none actual %h",
                             $time, rsp_item);
                end
                else
                begin
                    oldest = due_beats.pop_front();
                    checked++;
                    note_field("pixel_value", oldest.pixel_value, rsp_item.pixel_value);
                    note_field("out_of_range", oldest.out_of_range, rsp_item.out_of_range);
                    note_field("scaled_width", oldest.scaled_width, rsp_item.scaled_width);
                    note_field("scaled_height", oldest.scaled_height, rsp_item.scaled_height);
                    note_field("new_data_size", oldest.new_data_size, rsp_item.new_data_size);
                end
            end
            pending <= due_beats.size();
        end
    end

endmodule

>>> sim/tb_nearest_neighbor_image_scaler.sv
`timescale 1ns / 1ps

module tb_nearest_neighbor_image_scaler;
    import nnis_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    in_item_t              req_item = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    out_item_t             rsp_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SRC_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          mismatches;
    int          pending;
    int          checked;
    int          fetch_hits;
    int          cycle_count = 0;
    int          hold_left = 0;
    int unsigned beats_sent = 0;
    int unsigned settings_used = 1;
    bit          quiet = 1'b0;
    bit          hold_trigger = 1'b0;
    bit          hold_seen = 1'b0;
    bit          filled [STORE_DEPTH];

    // Stimulus-side view of the image geometry.
    int unsigned cur_w = 256;
    int unsigned cur_h = 256;
    int unsigned cur_c = 3;
    int unsigned cur_s = 256;
    int unsigned out_w = 256;
    int unsigned out_h = 256;

    nearest_neighbor_image_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nnis_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_item   (rsp_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .fetch_hits (fetch_hits)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, pending);
            $display("FAIL nearest_neighbor_image_scaler");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= !quiet && ($urandom_range(99) < 14);
        end
    end

    function automatic int unsigned scaled_dim(input int unsigned size);
        longint unsigned p;
        p = (longint'(size) * cur_s) >> SCALE_FRAC;
        return (p > 65535) ? 65535 : int'(p);
    endfunction

    // Store entry a fetch reads, or -1 when it reads none.
    function automatic int src_index(input int unsigned row, col, clr);
        longint unsigned sr, sc;
        if (row >= out_h || col >= out_w || clr >= cur_c || cur_s == 0)
            return -1;
        sr = (longint'(row) << SCALE_FRAC) / cur_s;
        sc = (longint'(col) << SCALE_FRAC) / cur_s;
        if (sr >= cur_h)
            sr = cur_h - 1;
        if (sc >= cur_w)
            sc = cur_w - 1;
        return int'((sr * MAX_WIDTH + sc) * MAX_COLORS + clr);
    endfunction

    task automatic send(input in_item_t it);
        if (!quiet && $urandom_range(99) < 14)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (it.cmd == CMD_WRITE && it.pix_row < cur_h && it.pix_col < cur_w
            && it.color_index < cur_c)
            filled[{it.pix_row[7:0], it.pix_col[7:0], it.color_index}] = 1'b1;
        beats_sent++;
    endtask

    task automatic send_write(input int unsigned row, col, clr, val);
        in_item_t it;
        it.cmd         = CMD_WRITE;
        it.pix_row     = COORD_W'(row);
        it.pix_col     = COORD_W'(col);
        it.color_index = CIDX_W'(clr);
        it.write_value = BYTE_W'(val);
        send(it);
    endtask

    // A fetch whose source byte was never stored gets that byte written first.
    task automatic send_fetch(input int unsigned row, col, clr);
        in_item_t it;
        int       a;
        a = src_index(row, col, clr);
        if (a >= 0 && !filled[a])
            send_write(a >> 10, (a >> 2) & 255, a & 3, $urandom_range(0, 255));
        it.cmd         = CMD_FETCH;
        it.pix_row     = COORD_W'(row);
        it.pix_col     = COORD_W'(col);
        it.color_index = CIDX_W'(clr);
        it.write_value = BYTE_W'($urandom_range(0, 255));
        send(it);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic configure(input int unsigned w, h, c, s, hdr);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SRC_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= CFG_SRC_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_index <= CFG_COLOR_COUNT;
        cfg_data  <= CFG_DATA_W'(c);
        @(posedge clk);
        cfg_index <= CFG_SCALE_Q;
        cfg_data  <= CFG_DATA_W'(s);
        @(posedge clk);
        cfg_index <= CFG_HEADER_BYTES;
        cfg_data  <= CFG_DATA_W'(hdr);
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
        cur_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
        cur_c = (c > MAX_COLORS) ? MAX_COLORS : c;
        cur_s = s;
        out_w = scaled_dim(cur_w);
        out_h = scaled_dim(cur_h);
        settings_used++;
    endtask

    task automatic random_items(input int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 40 && cur_w != 0 && cur_h != 0 && cur_c != 0)
                send_write($urandom_range(0, cur_h - 1), $urandom_range(0, cur_w - 1),
                           $urandom_range(0, cur_c - 1), $urandom_range(0, 255));
            else if (pick < 88)
                send_fetch((out_h == 0) ? $urandom_range(0, 3) : $urandom_range(0, out_h),
                           (out_w == 0) ? $urandom_range(0, 3) : $urandom_range(0, out_w),
                           $urandom_range(0, (cur_c > 3) ? 3 : cur_c));
            else if (pick < 94)
                send_write($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 3), $urandom_range(0, 255));
            else
                send_fetch($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 3));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: 256 x 256, 3 colors, scale 1.0
        send_write(0, 0, 0, 8'h00);
        send_write(255, 255, 2, 8'hFF);
        send_write(0, 255, 1, 8'hA5);
        send_write(255, 0, 0, 8'h5A);
        send_write(256, 0, 0, 8'h11);
        send_write(0, 256, 1, 8'h22);
        send_write(0, 0, 3, 8'h33);
        send_write(16'hFFFF, 16'hFFFF, 3, 8'hFF);
        send_fetch(0, 0, 0);
        send_fetch(255, 255, 2);
        send_fetch(0, 255, 1);
        send_fetch(255, 0, 0);
        send_fetch(256, 0, 0);
        send_fetch(0, 256, 0);
        send_fetch(0, 0, 3);
        send_fetch(16'hFFFF, 16'hFFFF, 3);

        // zero width: empty image
        configure(0, 5, 2, 256, 0);
        send_write(0, 0, 0, 8'h77);
        send_fetch(0, 0, 0);

        // oversized registers, largest scale and header
        configure(9'h1FF, 9'h1FF, 3'h7, 16'hFFFF, 16'hFFFF);
        send_fetch(16'hFFFF, 16'hFFFF, 3);
        send_fetch(0, 0, 0);
        send_fetch(255, 255, 2);

        // zero scale: every fetch out of range, the in-range write still lands
        configure(8, 8, 1, 0, 54);
        send_fetch(0, 0, 0);
        send_write(7, 7, 0, 8'h0F);

        for (int phase = 0; phase < 12; phase++)
        begin
            if ($urandom_range(3) == 0)
                configure($urandom_range(200, 511), $urandom_range(200, 511),
                          $urandom_range(0, 7), $urandom_range(1, 65535),
                          $urandom_range(0, 65535));
            else
                configure($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 4),
                          $urandom_range(32, 1536), $urandom_range(0, 65535));
            quiet <= (phase == 3);
            if (phase == 6 || phase == 10)
                hold_trigger <= ~hold_trigger;
            random_items(60);
        end

        drain();
        repeat (40) @(posedge clk);
        $display("covered %0d request beats across %0d image settings", beats_sent,
                 settings_used);
        $display("%0d response beats compared, %0d of them in-range fetches", checked,
                 fetch_hits);
        if (mismatches == 0 && pending == 0)
            $display("PASS nearest_neighbor_image_scaler");
        else
            $display("FAIL nearest_neighbor_image_scaler");
        $finish;
    end

endmodule

>>> nearest_neighbor_image_scaler.f
+incdir+design
design/nnis_pkg.sv
design/nnis_mul.sv
design/nnis_div.sv
design/nnis_store.sv
design/nearest_neighbor_image_scaler.sv
sim/nnis_checker.sv
sim/tb_nearest_neighbor_image_scaler.sv
